// ----- sv/lros_pkg.sv -----
// Package: sizes and record layouts of the local-ratio offload selector.
package lros_pkg;
  localparam int MaxInst = 1024;
  localparam int MaxApps = 64;
  localparam int MaxRsus = 16;
  localparam int MaxRes = 64;
  localparam int IW = $clog2(MaxInst);
  localparam int AW = $clog2(MaxApps);
  localparam int RW = $clog2(MaxRsus);
  localparam int ARW = AW + RW;
  localparam int ResW = $clog2(MaxRes + 1);
  localparam logic [39:0] AccMax = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic       heavy;
    logic [7:0] cus;
    logic [7:0] rbs;
    logic [3:0] rsu;
    logic [5:0] app;
  } alloc_t;

  typedef struct packed {
    logic [15:0] usage;
    logic [31:0] util;
  } value_t;

  // Add with saturation at the accumulator maximum.
  function automatic logic [39:0] sat_add(input logic [39:0] a, input logic [39:0] b);
    logic [40:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[40] ? AccMax : s[39:0];
  endfunction
endpackage

// ----- sv/local_ratio_offload_selector.sv -----
// Top level: local-ratio offload selector with memory-held instance state.
//
// Usage: the in_ channel takes one word per cycle while loading. kind 0 loads
// the RB/CU capacity of one RSU; kind 1 stores a candidate instance. An
// instance word with in_last set starts a selection run; in_ready stays low
// until every result word of the run has been taken on the out_ channel.
// Run steps: a clearing pass over the app-in-RSU accumulator memory
// (one entry per cycle, set by that memory's single write port), then
// phase one per stored instance per pass (two passes: light, then heavy):
// instance read, accumulator read, multiply, compare and write-back for an
// instance of the pass's class; the multiply is skipped for one of the other
// class. Phase two per popped candidate: stack read, instance read, fit
// check. Each pick is held until the next pick or the end of the run shows
// whether it is last, so every pick after the first adds an offer and a take
// step before it is recorded.
// Results come out in pop order; the last carries out_done_res, and a run
// with no pick yields one word with out_none_selected set.
// Reset clears counts, capacities and control; memories hold no reset value.
// A stall on out_ready holds the result register and freezes phase two.
module local_ratio_offload_selector
  import lros_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [5:0]  in_app_index,
  input  logic [3:0]  in_rsu_index,
  input  logic [7:0]  in_rbs,
  input  logic [7:0]  in_cus,
  input  logic [31:0] in_utility,
  input  logic [15:0] in_usage_sum,
  input  logic        in_is_heavy,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_inst_index,
  output logic [5:0]  out_sel_app,
  output logic [3:0]  out_sel_rsu,
  output logic [7:0]  out_sel_rbs,
  output logic [7:0]  out_sel_cus,
  output logic        out_none_selected,
  output logic        out_overflow,
  output logic        out_done_res
);

  typedef enum logic [3:0] {
    S_LOAD, S_CLEAR, S_P1_RD, S_P1_MEM, S_P1_MUL, S_P1_UPD,
    S_P2_RD, S_P2_MEM, S_P2_CHK, S_OUT
  } state_t;

  // Memories
  alloc_t      alloc_mem [MaxInst];
  value_t      value_mem [MaxInst];
  logic [IW-1:0] stack_mem [MaxInst];
  logic [39:0] arr_mem [MaxApps*MaxRsus];
  logic [39:0] app_red_mem [MaxApps];

  // Small per-RSU and per-app arrays in flops, indexed once per cycle
  logic [39:0] rsu_red_r [MaxRsus];
  logic [7:0]  rb_cap_r [MaxRsus];
  logic [7:0]  cu_cap_r [MaxRsus];
  logic [7:0]  rb_rem_r [MaxRsus];
  logic [7:0]  cu_rem_r [MaxRsus];
  logic [MaxApps-1:0] chosen_r;

  state_t      state_r;
  logic [IW:0] inst_cnt_r;
  logic [IW:0] cand_cnt_r;
  logic [IW:0] ptr_r;
  logic [ARW-1:0] clr_r;
  logic        heavy_pass_r;
  logic        ovf_r;
  logic        run_ovf_r;
  logic [ResW-1:0] n_out_r;
  logic        pend_r;

  // Read data registers
  alloc_t      alloc_q_r;
  value_t      value_q_r;
  logic [IW-1:0] idx_q_r;
  logic [IW-1:0] idx_r;
  logic [39:0] arr_q_r;
  logic [39:0] app_q_r;
  logic [39:0] cut_r;

  // Result register
  logic [9:0]  o_idx_r;
  alloc_t      o_al_r;
  logic        o_none_r;
  logic        o_done_r;
  logic        out_valid_r;

  logic [ARW-1:0] ar_addr;
  logic [39:0] red_rsu;
  logic [55:0] prod;
  logic [42:0] term;
  logic [43:0] cut_sum;
  logic [39:0] util_ext;
  logic [39:0] diff;
  logic        p2_ok;
  logic        last_pick;
  logic        in_acc;

  assign in_ready = (state_r == S_LOAD);
  assign in_acc = in_valid && in_ready;
  assign ar_addr = {alloc_q_r.app, alloc_q_r.rsu};

  // Phase-one arithmetic
  assign red_rsu = (rsu_red_r[alloc_q_r.rsu] > arr_q_r) ?
                   rsu_red_r[alloc_q_r.rsu] - arr_q_r : 40'd0;
  assign prod = red_rsu * value_q_r.usage;
  assign term = prod[55:13];
  assign cut_sum = {4'd0, app_q_r} + {1'b0, term};
  assign util_ext = {8'd0, value_q_r.util};
  assign diff = util_ext - cut_r;

  // Phase-two fit check
  assign p2_ok = !chosen_r[alloc_q_r.app] &&
                 (rb_rem_r[alloc_q_r.rsu] >= alloc_q_r.rbs) &&
                 (cu_rem_r[alloc_q_r.rsu] >= alloc_q_r.cus);
  assign last_pick = (n_out_r == ResW'(MaxRes - 1)) || (ptr_r == '0);

  // Memory ports: instance stores
  always_ff @(posedge clk) begin
    if (in_acc && in_kind && (inst_cnt_r < (IW+1)'(MaxInst))) begin
      alloc_mem[inst_cnt_r[IW-1:0]] <= '{heavy: in_is_heavy, cus: in_cus, rbs: in_rbs,
                                          rsu: in_rsu_index, app: in_app_index};
      value_mem[inst_cnt_r[IW-1:0]] <= '{usage: in_usage_sum, util: in_utility};
    end
    if (state_r == S_P1_RD) begin
      alloc_q_r <= alloc_mem[ptr_r[IW-1:0]];
      value_q_r <= value_mem[ptr_r[IW-1:0]];
    end else if (state_r == S_P2_MEM) begin
      alloc_q_r <= alloc_mem[idx_q_r];
    end
  end

  // Memory ports: candidate stack, read at the top entry when popping
  always_ff @(posedge clk) begin
    if (state_r == S_P1_UPD && (util_ext > cut_r))
      stack_mem[cand_cnt_r[IW-1:0]] <= idx_r;
    if (state_r == S_P2_RD && cand_cnt_r != '0)
      idx_q_r <= stack_mem[cand_cnt_r[IW-1:0] - 1'b1];
  end

  // Memory ports: accumulators
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      arr_mem[clr_r] <= '0;
      if (clr_r < ARW'(MaxApps)) app_red_mem[clr_r[AW-1:0]] <= '0;
    end else if (state_r == S_P1_UPD && (util_ext > cut_r)) begin
      arr_mem[ar_addr] <= sat_add(arr_q_r, diff);
      app_red_mem[alloc_q_r.app] <= sat_add(app_q_r, diff);
    end
    if (state_r == S_P1_MEM) begin
      arr_q_r <= arr_mem[ar_addr];
      app_q_r <= app_red_mem[alloc_q_r.app];
    end
  end

  // Control sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      inst_cnt_r <= '0;
      cand_cnt_r <= '0;
      ovf_r <= 1'b0;
      out_valid_r <= 1'b0;
      chosen_r <= '0;
      for (int i = 0; i < MaxRsus; i++) begin
        rb_cap_r[i] <= '0;
        cu_cap_r[i] <= '0;
      end
    end else begin
      case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (!in_kind) begin
              rb_cap_r[in_rsu_index] <= in_rbs;
              cu_cap_r[in_rsu_index] <= in_cus;
            end else begin
              if (inst_cnt_r < (IW+1)'(MaxInst)) inst_cnt_r <= inst_cnt_r + 1'b1;
              if (in_last) begin
                run_ovf_r <= ovf_r || (inst_cnt_r == (IW+1)'(MaxInst));
                clr_r <= '0;
                state_r <= S_CLEAR;
              end else if (inst_cnt_r == (IW+1)'(MaxInst)) begin
                ovf_r <= 1'b1;
              end
            end
          end
        end
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) begin
            for (int i = 0; i < MaxRsus; i++) begin
              rsu_red_r[i] <= '0;
              rb_rem_r[i] <= rb_cap_r[i];
              cu_rem_r[i] <= cu_cap_r[i];
            end
            chosen_r <= '0;
            cand_cnt_r <= '0;
            heavy_pass_r <= 1'b0;
            ptr_r <= '0;
            n_out_r <= '0;
            pend_r <= 1'b0;
            state_r <= (inst_cnt_r == '0) ? S_P2_RD : S_P1_RD;
          end
        end
        S_P1_RD: begin
          idx_r <= ptr_r[IW-1:0];
          state_r <= S_P1_MEM;
        end
        S_P1_MEM: begin
          // skip an instance of the other class by forcing a full cut
          if (alloc_q_r.heavy == heavy_pass_r) begin
            cut_r <= AccMax;
            state_r <= S_P1_MUL;
          end else begin
            cut_r <= {8'd0, 32'hFFFF_FFFF};
            state_r <= S_P1_UPD;
          end
        end
        S_P1_MUL: begin
          cut_r <= (cut_sum >= {12'd0, value_q_r.util}) ? util_ext : cut_sum[39:0];
          state_r <= S_P1_UPD;
        end
        S_P1_UPD: begin
          if (util_ext > cut_r) begin
            cand_cnt_r <= cand_cnt_r + 1'b1;
            rsu_red_r[alloc_q_r.rsu] <= sat_add(rsu_red_r[alloc_q_r.rsu], diff);
          end
          if (ptr_r + 1'b1 == inst_cnt_r) begin
            ptr_r <= '0;
            if (heavy_pass_r) begin
              state_r <= S_P2_RD;
            end else begin
              heavy_pass_r <= 1'b1;
              state_r <= S_P1_RD;
            end
          end else begin
            ptr_r <= ptr_r + 1'b1;
            state_r <= S_P1_RD;
          end
        end
        S_P2_RD: begin
          // stack empty: offer the held pick as last, or the empty marker
          if (cand_cnt_r == '0) begin
            if (!pend_r) begin
              o_idx_r <= '0;
              o_al_r <= '0;
              o_none_r <= 1'b1;
            end
            o_done_r <= 1'b1;
            out_valid_r <= 1'b1;
            state_r <= S_OUT;
          end else begin
            ptr_r <= cand_cnt_r - 1'b1;
            cand_cnt_r <= cand_cnt_r - 1'b1;
            state_r <= S_P2_MEM;
          end
        end
        S_P2_MEM: begin
          idx_r <= idx_q_r;
          state_r <= S_P2_CHK;
        end
        S_P2_CHK: begin
          if (out_valid_r) begin
            // hold until the offered word is taken
            if (out_ready) begin
              out_valid_r <= 1'b0;
              pend_r <= 1'b0;
            end
          end else if (p2_ok && pend_r) begin
            // a later pick exists: offer the held one, not last
            out_valid_r <= 1'b1;
          end else if (p2_ok) begin
            chosen_r[alloc_q_r.app] <= 1'b1;
            rb_rem_r[alloc_q_r.rsu] <= rb_rem_r[alloc_q_r.rsu] - alloc_q_r.rbs;
            cu_rem_r[alloc_q_r.rsu] <= cu_rem_r[alloc_q_r.rsu] - alloc_q_r.cus;
            o_idx_r <= 10'(idx_r);
            o_al_r <= '{heavy: 1'b0, cus: alloc_q_r.cus, rbs: alloc_q_r.rbs,
                        rsu: alloc_q_r.rsu, app: alloc_q_r.app};
            o_none_r <= 1'b0;
            o_done_r <= last_pick;
            out_valid_r <= last_pick;
            pend_r <= 1'b1;
            n_out_r <= n_out_r + 1'b1;
            state_r <= last_pick ? S_OUT : S_P2_RD;
          end else begin
            state_r <= S_P2_RD;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            inst_cnt_r <= '0;
            cand_cnt_r <= '0;
            ovf_r <= 1'b0;
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_inst_index = o_idx_r;
  assign out_sel_app = o_al_r.app;
  assign out_sel_rsu = o_al_r.rsu;
  assign out_sel_rbs = o_al_r.rbs;
  assign out_sel_cus = o_al_r.cus;
  assign out_none_selected = o_none_r;
  assign out_overflow = run_ovf_r;
  assign out_done_res = o_done_r;

endmodule

// ----- bench/tb_top.sv -----
// Testbench for the local-ratio offload selector: directed and random runs against a predictor.
module tb_top
  import lros_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 40000;
  localparam int MaxErrShown = 10;

  typedef struct {
    bit        kind;
    bit [5:0]  app;
    bit [3:0]  rsu;
    bit [7:0]  rbs;
    bit [7:0]  cus;
    bit [31:0] util;
    bit [15:0] usage;
    bit        heavy;
    bit        last;
  } word_t;

  typedef struct packed {
    bit [9:0] inst;
    bit [5:0] app;
    bit [3:0] rsu;
    bit [7:0] rbs;
    bit [7:0] cus;
    bit       none;
    bit       ovf;
    bit       done;
  } pick_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic [5:0]  in_app_index = '0;
  logic [3:0]  in_rsu_index = '0;
  logic [7:0]  in_rbs = '0;
  logic [7:0]  in_cus = '0;
  logic [31:0] in_utility = '0;
  logic [15:0] in_usage_sum = '0;
  logic        in_is_heavy = 1'b0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  out_inst_index;
  logic [5:0]  out_sel_app;
  logic [3:0]  out_sel_rsu;
  logic [7:0]  out_sel_rbs;
  logic [7:0]  out_sel_cus;
  logic        out_none_selected;
  logic        out_overflow;
  logic        out_done_res;

  local_ratio_offload_selector DUT (.*);

  // Clock: 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow state of the selector
  alloc_t      inst_alloc [MaxInst];
  value_t      inst_value [MaxInst];
  int          n_stored;
  bit          dropped_any;
  bit [39:0]   red_app [MaxApps];
  bit [39:0]   red_rsu [MaxRsus];
  bit [39:0]   red_app_rsu [MaxApps*MaxRsus];
  int          cand_stack [MaxInst];
  int          n_cand;
  bit          app_taken [MaxApps];
  bit [7:0]    rb_cap [MaxRsus];
  bit [7:0]    cu_cap [MaxRsus];
  bit [7:0]    rb_left [MaxRsus];
  bit [7:0]    cu_left [MaxRsus];

  pick_t       pick_q [$];
  int          errors = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int          rx_hold_req = 0;

  function automatic bit [39:0] acc_add(bit [39:0] a, bit [39:0] b);
    bit [40:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[40] ? 40'hFF_FFFF_FFFF : s[39:0];
  endfunction

  // Phase one: lower each instance's utility, keep the positive survivors
  task automatic scan_class(input bit heavy);
    alloc_t     al;
    bit [63:0]  util, cut, rr, v;
    int         ar;
    for (int i = 0; i < n_stored; i++) begin
      al = inst_alloc[i];
      if (al.heavy != heavy) continue;
      ar = al.app * MaxRsus + al.rsu;
      util = inst_value[i].util;
      rr = (red_rsu[al.rsu] > red_app_rsu[ar]) ? red_rsu[al.rsu] - red_app_rsu[ar] : 0;
      cut = red_app[al.app] + ((rr * inst_value[i].usage) >> 13);
      if (util <= cut) continue;
      v = util - cut;
      cand_stack[n_cand++] = i;
      red_app[al.app] = acc_add(red_app[al.app], v[39:0]);
      red_rsu[al.rsu] = acc_add(red_rsu[al.rsu], v[39:0]);
      red_app_rsu[ar] = acc_add(red_app_rsu[ar], v[39:0]);
    end
  endtask

  // Run both phases and queue the picks in pop order
  task automatic run_selection();
    alloc_t al;
    pick_t  p;
    int     n_out;
    n_out = 0;
    foreach (red_app[a]) red_app[a] = '0;
    foreach (red_rsu[r]) red_rsu[r] = '0;
    foreach (red_app_rsu[k]) red_app_rsu[k] = '0;
    foreach (app_taken[a]) app_taken[a] = 1'b0;
    rb_left = rb_cap;
    cu_left = cu_cap;
    n_cand = 0;
    scan_class(1'b0);
    scan_class(1'b1);
    for (int k = n_cand; k > 0 && n_out < MaxRes; k--) begin
      al = inst_alloc[cand_stack[k-1]];
      if (app_taken[al.app]) continue;
      if (rb_left[al.rsu] < al.rbs || cu_left[al.rsu] < al.cus) continue;
      app_taken[al.app] = 1'b1;
      rb_left[al.rsu] -= al.rbs;
      cu_left[al.rsu] -= al.cus;
      p = '{inst: 10'(cand_stack[k-1]), app: al.app, rsu: al.rsu, rbs: al.rbs, cus: al.cus,
            none: 1'b0, ovf: dropped_any, done: 1'b0};
      pick_q = {pick_q, p};
      n_out++;
    end
    if (n_out == 0) begin
      p = '0;
      p.none = 1'b1;
      p.ovf = dropped_any;
      p.done = 1'b1;
      pick_q = {pick_q, p};
    end else begin
      pick_q[$].done = 1'b1;
    end
    n_stored = 0;
    n_cand = 0;
    dropped_any = 1'b0;
  endtask

  // Update the shadow state with one accepted word
  task automatic absorb_word(input word_t w);
    if (!w.kind) begin
      rb_cap[w.rsu] = w.rbs;
      cu_cap[w.rsu] = w.cus;
      return;
    end
    if (n_stored < MaxInst) begin
      inst_alloc[n_stored] = '{heavy: w.heavy, cus: w.cus, rbs: w.rbs, rsu: w.rsu, app: w.app};
      inst_value[n_stored] = '{usage: w.usage, util: w.util};
      n_stored++;
    end else begin
      dropped_any = 1'b1;
    end
    if (w.last) run_selection();
  endtask

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 15);
    if (r < 10) return 0;
    if (r < 15) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic word_t inst_word(int app, int rsu, int rbs, int cus, bit [31:0] util,
                                      int usage, int heavy, bit last);
    word_t w;
    w = '{kind: 1'b1, app: 6'(app), rsu: 4'(rsu), rbs: 8'(rbs), cus: 8'(cus), util: util,
          usage: 16'(usage), heavy: 1'(heavy), last: last};
    return w;
  endfunction

  function automatic word_t cap_word(int rsu, int rbs, int cus, int last);
    word_t w;
    w = '{kind: 1'b0, app: 6'($urandom), rsu: 4'(rsu), rbs: 8'(rbs), cus: 8'(cus),
          util: $urandom, usage: 16'($urandom), heavy: 1'($urandom), last: 1'(last)};
    return w;
  endfunction

  // Offer one word and hold it until accepted
  task automatic send_word(input word_t w);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= w.kind;
    in_app_index <= w.app;
    in_rsu_index <= w.rsu;
    in_rbs       <= w.rbs;
    in_cus       <= w.cus;
    in_utility   <= w.util;
    in_usage_sum <= w.usage;
    in_is_heavy  <= w.heavy;
    in_last      <= w.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_word(w);
  endtask

  // Receiver: random stalls, plus a long hold on request
  always @(posedge clk) begin : rx_drive
    int stall;
    if (rx_hold_req > 0) begin
      stall = rx_hold_req;
      rx_hold_req = 0;
    end
    if (stall > 0) begin
      out_ready <= 1'b0;
      stall--;
    end else begin
      out_ready <= 1'b1;
      stall = pick_gap(rx_calm);
    end
  end

  // Compare each taken word against the oldest expected pick
  always @(posedge clk) begin : check_picks
    pick_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{inst: out_inst_index, app: out_sel_app, rsu: out_sel_rsu, rbs: out_sel_rbs,
              cus: out_sel_cus, none: out_none_selected, ovf: out_overflow,
              done: out_done_res};
      if (pick_q.size() == 0) begin
        errors++;
        if (errors <= MaxErrShown) $display("unexpected result word %p", got);
      end else begin
        want = pick_q.pop_front();
        if (got.inst != want.inst || got.app != want.app || got.rsu != want.rsu ||
            got.rbs != want.rbs || got.cus != want.cus || got.none != want.none ||
            got.ovf != want.ovf || got.done != want.done) begin
          errors++;
          if (errors <= MaxErrShown) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin : watchdog
    int idle;
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
    else idle++;
    if (idle >= IdleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Extremes of every field and the named corner cases
  task automatic test_directed();
    // no capacity loaded yet: nothing fits
    send_word(inst_word(0, 0, 1, 1, 32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b1));
    // capacity load with last set loads only
    send_word(cap_word(0, 255, 255, 1));
    send_word(cap_word(15, 8'hFF, 8'h00, 0));
    send_word(cap_word(1, 10, 20, 0));
    send_word(inst_word(63, 15, 255, 0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0));
    send_word(inst_word(63, 15, 1, 0, 32'h0001_0000, 16'h8000, 1'b0, 1'b0));
    send_word(inst_word(0, 0, 255, 255, 32'h0000_0001, 16'h0000, 1'b0, 1'b0));
    send_word(inst_word(5, 0, 0, 0, 32'h0000_0000, 16'h4000, 1'b1, 1'b0));
    send_word(inst_word(5, 1, 10, 20, 32'h8000_0000, 16'hFFFF, 1'b1, 1'b0));
    send_word(inst_word(6, 1, 11, 1, 32'h7FFF_FFFF, 16'h8000, 1'b0, 1'b0));
    send_word(inst_word(42, 10, 85, 170, 32'hAAAA_5555, 16'h5555, 1'b0, 1'b1));
    // zero utility everywhere: nothing survives
    send_word(inst_word(1, 0, 0, 0, 32'h0, 16'h0, 1'b0, 1'b0));
    send_word(inst_word(2, 0, 0, 0, 32'h0, 16'h0, 1'b1, 1'b1));
  endtask

  // Run of picks while the receiver holds off and the sender keeps offering
  task automatic test_backpressure();
    send_word(cap_word(3, 255, 255, 0));
    for (int a = 0; a < 20; a++)
      send_word(inst_word(a % MaxApps, 3, 0, 0, 32'h0001_0000 + a, 16'h0, a[0], a == 19));
    rx_hold_req = 3000;
    for (int k = 0; k < 4; k++)
      send_word(inst_word($urandom_range(0, 63), 3, 1, 1, $urandom, $urandom, 1'b0, k == 3));
  endtask

  // Random runs of random instances with capacity loads mixed in
  task automatic test_random();
    int sent, n;
    word_t w;
    sent = 0;
    for (int r = 0; r < 16; r++)
      send_word(cap_word(r, $urandom_range(0, 255), $urandom_range(0, 255), $urandom));
    while (sent < 45) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 5) == 0)
          send_word(cap_word($urandom_range(0, 15), $urandom, $urandom, $urandom));
        w = inst_word($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 63),
                      $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 15),
                      $urandom_range(0, 2) ? $urandom_range(0, 80) : $urandom_range(0, 255),
                      $urandom_range(0, 2) ? $urandom_range(0, 80) : $urandom_range(0, 255),
                      $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0010_0000),
                      $urandom_range(0, 4) ? $urandom_range(0, 32768) : $urandom_range(0, 65535),
                      $urandom, i == n - 1);
        send_word(w);
        sent++;
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    n_stored = 0;
    dropped_any = 1'b0;
    foreach (rb_cap[r]) begin
      rb_cap[r] = '0;
      cu_cap[r] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    // drain outstanding picks, then let the block settle
    while (pick_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/lros_pkg.sv
sv/local_ratio_offload_selector.sv
bench/tb_top.sv
